[design/isst_pkg.sv]
package isst_pkg;

	localparam int SLOTS  = 16;
	localparam int MARK_W = $clog2(SLOTS + 1);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int REM_W  = 5;
	localparam int REM_MAX = (1 << REM_W) - 1;

	typedef enum logic [2:0] {
		CMD_CLEAR   = 3'd0,
		CMD_ADD     = 3'd1,
		CMD_DEL     = 3'd2,
		CMD_DEL_ALL = 3'd3,
		CMD_EXISTS  = 3'd4,
		CMD_EMPTY   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [REM_W-1:0] remaining;
		logic             is_empty;
		logic             found;
		logic [1:0]       status;
	} result_t;

endpackage

[design/id_slot_set_table.sv]
// Result: the result is registered and appears in the cycle after its command word is accepted.
// Throughput: one command per cycle while results are taken; all slots are matched in parallel and the
// output register is reloaded in the same cycle it is taken.
// Reset: arst_n clears all slots, the high-water mark and the output valid
// at once; no clearing pass.
module id_slot_set_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // cmd[2:0], id[34:3], zero[39:35]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status[1:0], found[2], remaining[7:3], is_empty[8], zero
);

	isst_pkg::ctrl_cmd_t cmd;
	isst_pkg::result_t   res;

	isst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd)
	);

	isst_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.op     (s_tdata[2:0]),
		.id     (s_tdata[34:3]),
		.res    (res)
	);

	assign m_tdata = {7'd0, res.is_empty, res.remaining, res.found, res.status};

endmodule

[design/isst_ctrl.sv]
module isst_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_ready,
	output logic                 in_ready,
	output logic                 out_valid,
	output isst_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t state_q;

	assign out_valid = (state_q == S_HOLD);
	// free the output register while it is being taken
	assign in_ready  = (state_q == S_IDLE) || out_ready;
	assign cmd.exec  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.exec) state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (cmd.exec) state_q <= S_HOLD;
					else if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[design/isst_dp.sv]
module isst_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  isst_pkg::ctrl_cmd_t  cmd,
	input  logic [2:0]           op,
	input  logic [31:0]          id,
	output isst_pkg::result_t    res
);

	localparam int N = isst_pkg::SLOTS;
	localparam int MW = isst_pkg::MARK_W;

	logic [31:0]   slot_q [N];
	logic [MW-1:0] hw_q;

	logic [N-1:0] below, nz, match, free, free_first, dm, dm_first;
	logic [MW-1:0] free_pos;
	logic [isst_pkg::CNT_W-1:0] cnt;
	logic [N-1:0] clr_mask;
	logic         do_add, do_clear;
	logic [MW-1:0] hw_d;
	isst_pkg::result_t res_d;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			below[i] = MW'(i) < hw_q;
			nz[i]    = |slot_q[i];
			match[i] = (slot_q[i] == id);
		end
		free       = ~nz;
		free_first = free & (~free + 1'b1);
		dm         = match & below;
		dm_first   = dm & (~dm + 1'b1);
		free_pos   = '0;
		for (int i = 0; i < N; i++) begin
			if (free_first[i]) free_pos = free_pos | MW'(i + 1);
		end
		cnt = isst_pkg::CNT_W'($countones(below & nz & ~match));
	end

	always_comb begin
		res_d    = '0;
		clr_mask = '0;
		do_add   = 1'b0;
		do_clear = 1'b0;
		hw_d     = hw_q;
		unique case (isst_pkg::cmd_t'(op))
			isst_pkg::CMD_CLEAR: begin
				do_clear = 1'b1;
			end
			isst_pkg::CMD_ADD: begin
				if (|free) begin
					do_add = 1'b1;
					if (free_pos > hw_q) hw_d = free_pos;
				end else begin
					res_d.status = isst_pkg::ST_FULL;
				end
			end
			isst_pkg::CMD_DEL: begin
				clr_mask = dm_first;
				if (!(|dm)) res_d.status = isst_pkg::ST_NOT_FOUND;
			end
			isst_pkg::CMD_DEL_ALL: begin
				clr_mask = dm;
				if (|dm) begin
					res_d.remaining = (32'(cnt) > 32'(isst_pkg::REM_MAX)) ?
						isst_pkg::REM_W'(isst_pkg::REM_MAX) : isst_pkg::REM_W'(cnt);
				end else begin
					res_d.status = isst_pkg::ST_NOT_FOUND;
				end
			end
			isst_pkg::CMD_EXISTS: begin
				res_d.found = |dm;
			end
			isst_pkg::CMD_EMPTY: begin
				res_d.is_empty = ~|(below & nz);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= '0;
			for (int i = 0; i < N; i++) slot_q[i] <= '0;
		end else if (cmd.exec) begin
			if (do_clear) begin
				hw_q <= '0;
				for (int i = 0; i < N; i++) slot_q[i] <= '0;
			end else begin
				hw_q <= hw_d;
				for (int i = 0; i < N; i++) begin
					if (clr_mask[i]) slot_q[i] <= '0;
					else if (do_add && free_first[i]) slot_q[i] <= id;
				end
			end
		end
	end

	// result register, loaded with each accepted word
	always_ff @(posedge clk) begin
		if (cmd.exec) res <= res_d;
	end

endmodule

[design/isst_checker.sv]
module isst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid right after reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted command word gave no result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result stalled");

	a_legal_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:9] == 7'd0 && m_tdata[1:0] != 2'd3)
		else $error("result word carries an illegal code");

endmodule

bind id_slot_set_table isst_checker u_isst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
